// File: rtl/nearest_obstacle_finder_assert.svh
// Assertion macros shared by the nearest obstacle finder modules.
// Included by nof_ctrl and nof_dp; depends on nothing else.
`ifndef NEAREST_OBSTACLE_FINDER_ASSERT_SVH
`define NEAREST_OBSTACLE_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked in normal operation, skipped while reset is high.
`define NOF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nearest obstacle finder assertion failed");
// Checked at every edge, reset included.
`define NOF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("nearest obstacle finder assertion failed");
`else
`define NOF_ASSERT(label, clk, rst, prop)
`define NOF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/nof_pkg.sv
// Shared types and constants of the nearest obstacle finder.
// Used by nof_ctrl, nof_dp and the top level; depends on nothing.
package nof_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int REDUCE_STEPS = 10;
   localparam int ITER_W       = 5;
   localparam int XY_W         = 35;
   localparam int Z_W          = 28;
   localparam int REM_W        = 36;
   localparam int FIN_W        = 20;

   // Angles in 2^-24 rad for the trigonometry.
   localparam logic [26:0]            TWO_PI_Q24   = 27'd105414357;
   localparam logic [26:0]            WRAP_LIMIT   = 27'd52707178;
   localparam logic signed [Z_W-1:0]  PI_Q24       = 28'sd52707179;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q24  = 28'sd26353589;
   localparam logic [15:0]            GAIN_Q16     = 16'd39796;
   localparam logic signed [FIN_W-1:0] XY_LIMIT    = 20'sd65535;
   localparam logic signed [XY_W-1:0] ROUND_HALF   = 35'sd32768;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd3;

   localparam logic [15:0]        CEILING_RESET   = 16'd65535;
   localparam logic signed [18:0] START_RESET     = -19'sd205887;
   localparam logic [15:0]        STEP_RESET      = 16'd1147;
   localparam logic [15:0]        THRESHOLD_RESET = 16'd5000;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL,
      OP_ANGLE,
      OP_ABS,
      OP_REDUCE,
      OP_WRAP,
      OP_FOLD,
      OP_ROTATE,
      OP_FINISH,
      OP_LOAD
   } op_type;

   typedef struct packed {
      logic              accept;
      logic              close;
      op_type            op;
      logic [ITER_W-1:0] iter;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

   function automatic logic [23:0] atan_q24(input logic [ITER_W-1:0] i);
      logic [23:0] v;
      unique case (i)
         5'd0:    v = 24'd13176795;
         5'd1:    v = 24'd7778716;
         5'd2:    v = 24'd4110060;
         5'd3:    v = 24'd2086331;
         5'd4:    v = 24'd1047214;
         5'd5:    v = 24'd524117;
         5'd6:    v = 24'd262123;
         5'd7:    v = 24'd131069;
         5'd8:    v = 24'd65536;
         5'd9:    v = 24'd32768;
         5'd10:   v = 24'd16384;
         5'd11:   v = 24'd8192;
         5'd12:   v = 24'd4096;
         5'd13:   v = 24'd2048;
         5'd14:   v = 24'd1024;
         5'd15:   v = 24'd512;
         5'd16:   v = 24'd256;
         5'd17:   v = 24'd128;
         5'd18:   v = 24'd64;
         5'd19:   v = 24'd32;
         5'd20:   v = 24'd16;
         5'd21:   v = 24'd8;
         5'd22:   v = 24'd4;
         5'd23:   v = 24'd2;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [16:0] clamp_xy(input logic signed [FIN_W-1:0] v);
      logic signed [16:0] r;
      if (v > XY_LIMIT) begin
         r = 17'sd65535;
      end else if (v < -XY_LIMIT) begin
         r = -17'sd65535;
      end else begin
         r = 17'(v);
      end
      return r;
   endfunction

endpackage

// File: rtl/nof_ctrl.sv
// Sequencer of the nearest obstacle finder: input handshake and the steps
// of the per-scan trigonometry. Depends on nof_pkg and the assertion header.
`include "nearest_obstacle_finder_assert.svh"

module nof_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_scan_end,
   output logic             req_ready,
   input  nof_pkg::sts_type sts,
   output nof_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ANGLE,
      S_ABS,
      S_REDUCE,
      S_WRAP,
      S_FOLD,
      S_ROTATE,
      S_FINISH,
      S_LOAD
   } state_type;

   state_type                  state_ff, state_in;
   logic [nof_pkg::ITER_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.accept = 1'b0;
      cmd.close  = 1'b0;
      cmd.op     = nof_pkg::OP_NONE;
      cmd.iter   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            cmd.close  = req_valid && req_scan_end;
            if (req_valid && req_scan_end) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op   = nof_pkg::OP_MUL;
            state_in = S_ANGLE;
         end
         S_ANGLE: begin
            cmd.op   = nof_pkg::OP_ANGLE;
            state_in = S_ABS;
         end
         S_ABS: begin
            cmd.op   = nof_pkg::OP_ABS;
            cnt_in   = nof_pkg::ITER_W'(nof_pkg::REDUCE_STEPS - 1);
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            // The count runs down: largest multiple of 2*pi first.
            cmd.op = nof_pkg::OP_REDUCE;
            if (cnt_ff == '0) begin
               state_in = S_WRAP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_WRAP: begin
            cmd.op   = nof_pkg::OP_WRAP;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.op   = nof_pkg::OP_FOLD;
            cnt_in   = '0;
            state_in = S_ROTATE;
         end
         S_ROTATE: begin
            cmd.op = nof_pkg::OP_ROTATE;
            if (cnt_ff == nof_pkg::ITER_W'(nof_pkg::CORDIC_STEPS - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            cmd.op   = nof_pkg::OP_FINISH;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // Wait until the output register is free of an untaken result.
            if (!sts.out_busy) begin
               cmd.op   = nof_pkg::OP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `NOF_ASSERT(a_close_starts_trig, clock, reset, cmd.close |=> state_ff == S_MUL)
   `NOF_ASSERT(a_reduce_count, clock, reset, (state_ff == S_REDUCE) |-> (cnt_ff < nof_pkg::ITER_W'(nof_pkg::REDUCE_STEPS)))
   `NOF_ASSERT(a_rotate_count, clock, reset, (state_ff == S_ROTATE) |-> (cnt_ff < nof_pkg::ITER_W'(nof_pkg::CORDIC_STEPS)))

endmodule

// File: rtl/nof_dp.sv
// Datapath of the nearest obstacle finder: configuration registers, running
// minimum, angle reduction, CORDIC and output register. Depends on nof_pkg.
`include "nearest_obstacle_finder_assert.svh"

module nof_dp #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  nof_pkg::cmd_type                   cmd,
   output nof_pkg::sts_type                   sts,
   input  logic [15:0]                        req_range_mm,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nof_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nof_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_nearest_mm,
   output logic [9:0]                         rsp_nearest_index,
   output logic signed [27:0]                 rsp_nearest_angle,
   output logic                               rsp_move_flag,
   output logic signed [16:0]                 rsp_marker_x_mm,
   output logic signed [16:0]                 rsp_marker_y_mm,
   output logic [31:0]                        rsp_scan_number
);

   localparam int POS_W  = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int PROD_W = IDX_W + 16;

   // Configuration registers.
   logic [15:0]        ceiling_ff, step_ff, thresh_ff;
   logic signed [18:0] start_ff;

   // Running minimum of the open scan.
   logic [POS_W-1:0]   pos_ff;
   logic [15:0]        run_min_ff;
   logic [IDX_W-1:0]   min_idx_ff;
   logic [31:0]        scan_cnt_ff;

   // Closed scan under computation.
   logic [15:0]                     e_min_ff;
   logic [IDX_W-1:0]                e_idx_ff;
   logic                            e_flag_ff;
   logic [31:0]                     e_scan_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic signed [27:0]              angle_ff;
   logic [nof_pkg::REM_W-1:0]       rem_ff;
   logic                            neg_ff;
   logic signed [nof_pkg::Z_W-1:0]  z_ff;
   logic                            fold_ff;
   logic signed [nof_pkg::XY_W-1:0] x_ff, y_ff;
   logic signed [nof_pkg::FIN_W-1:0] fx_ff, fy_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [15:0]         out_mm_ff;
   logic [9:0]          out_idx_ff;
   logic signed [27:0]  out_angle_ff;
   logic                out_flag_ff;
   logic signed [16:0]  out_x_ff, out_y_ff;
   logic [31:0]         out_scan_ff;

   // Sample comparison.
   logic               first_sample, in_range, take;
   logic [15:0]        cur_min, nxt_min;
   logic [IDX_W-1:0]   cur_idx, nxt_idx;

   // Trigonometry helpers.
   logic [31:0]                      x0_prod;
   logic [PROD_W-1:0]                pos_prod;
   logic [27:0]                      angle_sum;
   logic signed [nof_pkg::REM_W-1:0] angle_q24;
   logic [nof_pkg::REM_W-1:0]        angle_mag;
   logic [nof_pkg::REM_W-1:0]        sub_val;
   logic [26:0]                      rem_low, z_pos;
   logic signed [nof_pkg::Z_W-1:0]   z_wrap;
   logic signed [nof_pkg::XY_W-1:0]  dx, dy;
   logic signed [nof_pkg::Z_W-1:0]   at_s;
   logic signed [nof_pkg::XY_W-1:0]  rnd_x, rnd_y, shx, shy;
   logic signed [nof_pkg::FIN_W-1:0] rx, ry;

   assign csr_ready     = 1'b1;
   assign sts.out_busy  = rsp_valid_ff && !rsp_ready;

   // The first sample of a scan compares against the ceiling as it is now.
   assign first_sample = (pos_ff == '0);
   assign cur_min      = first_sample ? ceiling_ff : run_min_ff;
   assign cur_idx      = first_sample ? '0 : min_idx_ff;
   assign in_range     = (pos_ff < POS_W'(MAX_SAMPLES));
   assign take         = in_range && (req_range_mm < cur_min);
   assign nxt_min      = take ? req_range_mm : cur_min;
   assign nxt_idx      = take ? pos_ff[IDX_W-1:0] : cur_idx;

   assign x0_prod   = 32'(e_min_ff) * 32'(nof_pkg::GAIN_Q16);
   assign pos_prod  = PROD_W'(e_idx_ff) * PROD_W'(step_ff);
   assign angle_sum = 28'(start_ff) + 28'(prod_ff);

   // Angle in 2^-24 rad and its magnitude; reduction works on the magnitude.
   assign angle_q24 = nof_pkg::REM_W'(angle_ff) <<< 8;
   assign angle_mag = angle_ff[27] ? (~angle_q24 + 1'b1) : angle_q24;
   assign sub_val   = nof_pkg::REM_W'(nof_pkg::TWO_PI_Q24) << cmd.iter;

   // A negative angle with a nonzero remainder lands at 2*pi minus it.
   assign rem_low = rem_ff[26:0];
   assign z_pos   = (neg_ff && (rem_low != '0)) ? (nof_pkg::TWO_PI_Q24 - rem_low) : rem_low;
   assign z_wrap  = (z_pos > nof_pkg::WRAP_LIMIT)
                    ? (nof_pkg::Z_W'(z_pos) - nof_pkg::Z_W'(nof_pkg::TWO_PI_Q24))
                    : nof_pkg::Z_W'(z_pos);

   assign dx   = y_ff >>> cmd.iter;
   assign dy   = x_ff >>> cmd.iter;
   assign at_s = nof_pkg::Z_W'(nof_pkg::atan_q24(cmd.iter));

   assign rnd_x = x_ff + nof_pkg::ROUND_HALF;
   assign rnd_y = y_ff + nof_pkg::ROUND_HALF;
   assign shx   = rnd_x >>> 16;
   assign shy   = rnd_y >>> 16;
   assign rx    = nof_pkg::FIN_W'(shx);
   assign ry    = nof_pkg::FIN_W'(shy);

   // Configuration and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff  <= nof_pkg::CEILING_RESET;
         start_ff    <= nof_pkg::START_RESET;
         step_ff     <= nof_pkg::STEP_RESET;
         thresh_ff   <= nof_pkg::THRESHOLD_RESET;
         pos_ff      <= '0;
         scan_cnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               nof_pkg::CSR_CEILING:   ceiling_ff <= csr_data[15:0];
               nof_pkg::CSR_START:     start_ff   <= csr_data;
               nof_pkg::CSR_STEP:      step_ff    <= csr_data[15:0];
               nof_pkg::CSR_THRESHOLD: thresh_ff  <= csr_data[15:0];
            endcase
         end
         if (cmd.accept) begin
            if (cmd.close) begin
               pos_ff      <= '0;
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
            end else if (in_range) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         run_min_ff <= nxt_min;
         min_idx_ff <= nxt_idx;
      end
      if (cmd.close) begin
         e_min_ff  <= nxt_min;
         e_idx_ff  <= nxt_idx;
         e_flag_ff <= (nxt_min < thresh_ff);
         e_scan_ff <= scan_cnt_ff;
      end
      unique case (cmd.op)
         nof_pkg::OP_MUL: begin
            prod_ff <= pos_prod;
            x_ff    <= nof_pkg::XY_W'(x0_prod);
            y_ff    <= '0;
         end
         nof_pkg::OP_ANGLE: begin
            angle_ff <= angle_sum;
         end
         nof_pkg::OP_ABS: begin
            neg_ff <= angle_ff[27];
            rem_ff <= angle_mag;
         end
         nof_pkg::OP_REDUCE: begin
            if (rem_ff >= sub_val) begin
               rem_ff <= rem_ff - sub_val;
            end
         end
         nof_pkg::OP_WRAP: begin
            z_ff <= z_wrap;
         end
         nof_pkg::OP_FOLD: begin
            // Beyond a quarter turn: rotate by pi and negate the results later.
            if (z_ff > nof_pkg::HALF_PI_Q24) begin
               z_ff    <= z_ff - nof_pkg::PI_Q24;
               fold_ff <= 1'b1;
            end else if (z_ff < -nof_pkg::HALF_PI_Q24) begin
               z_ff    <= z_ff + nof_pkg::PI_Q24;
               fold_ff <= 1'b1;
            end else begin
               fold_ff <= 1'b0;
            end
         end
         nof_pkg::OP_ROTATE: begin
            if (!z_ff[nof_pkg::Z_W-1]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at_s;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at_s;
            end
         end
         nof_pkg::OP_FINISH: begin
            fx_ff <= fold_ff ? -rx : rx;
            fy_ff <= fold_ff ? -ry : ry;
         end
         nof_pkg::OP_LOAD: begin
            out_mm_ff    <= e_min_ff;
            out_idx_ff   <= 10'(e_idx_ff);
            out_angle_ff <= angle_ff;
            out_flag_ff  <= e_flag_ff;
            out_x_ff     <= nof_pkg::clamp_xy(fx_ff);
            out_y_ff     <= nof_pkg::clamp_xy(fy_ff);
            out_scan_ff  <= e_scan_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == nof_pkg::OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_mm    = out_mm_ff;
   assign rsp_nearest_index = out_idx_ff;
   assign rsp_nearest_angle = out_angle_ff;
   assign rsp_move_flag     = out_flag_ff;
   assign rsp_marker_x_mm   = out_x_ff;
   assign rsp_marker_y_mm   = out_y_ff;
   assign rsp_scan_number   = out_scan_ff;

   `NOF_ASSERT(a_pos_bounded, clock, reset, pos_ff <= POS_W'(MAX_SAMPLES))
   `NOF_ASSERT(a_reduce_done, clock, reset, (cmd.op == nof_pkg::OP_REDUCE && cmd.iter == '0) |=> (rem_ff < nof_pkg::REM_W'(nof_pkg::TWO_PI_Q24)))
   `NOF_ASSERT(a_fold_range, clock, reset, (cmd.op == nof_pkg::OP_FOLD) |=> (z_ff <= nof_pkg::HALF_PI_Q24 && z_ff >= -nof_pkg::HALF_PI_Q24))

endmodule

// File: rtl/nearest_obstacle_finder.sv
// Nearest obstacle finder: running minimum over a laser scan with a
// polar-to-Cartesian marker by CORDIC. Uses nof_pkg, nof_ctrl and nof_dp.
//
// Usage:
//   req_* carries one range sample per item; req_scan_end marks the last
//   sample of a scan. Samples are taken one per cycle while the block is idle.
//   rsp_* carries one result per scan: minimum, its index and angle, the move
//   flag, the marker x and y, and the scan number.
//   csr_* writes the four configuration registers (ceiling, start angle,
//   angle step, near threshold); csr_ready is always high.
// Sequence:
//   After the item with req_scan_end the trigonometry sequencer runs through
//   products, angle, 10 steps of modulo 2*pi reduction, wrap and fold, 24
//   CORDIC rotations, rounding and output load; req_ready stays low during
//   that time, and rsp_valid rises once the output load has taken place.
// Reset: synchronous; configuration registers take reset values, counts clear, no result is pending.
// Stall: a result waits in the output register; the next scan is taken
//   meanwhile, and its result is held back until the earlier one is taken.
module nearest_obstacle_finder #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [15:0]                     req_range_mm,
   input  logic                            req_scan_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_nearest_mm,
   output logic [9:0]                      rsp_nearest_index,
   output logic signed [27:0]              rsp_nearest_angle,
   output logic                            rsp_move_flag,
   output logic signed [16:0]              rsp_marker_x_mm,
   output logic signed [16:0]              rsp_marker_y_mm,
   output logic [31:0]                     rsp_scan_number,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nof_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nof_pkg::CSR_DATA_W-1:0]  csr_data
);

   nof_pkg::cmd_type cmd;
   nof_pkg::sts_type sts;

   nof_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_scan_end (req_scan_end),
      .req_ready    (req_ready),
      .sts          (sts),
      .cmd          (cmd)
   );

   nof_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_range_mm      (req_range_mm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_mm    (rsp_nearest_mm),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_nearest_angle (rsp_nearest_angle),
      .rsp_move_flag     (rsp_move_flag),
      .rsp_marker_x_mm   (rsp_marker_x_mm),
      .rsp_marker_y_mm   (rsp_marker_y_mm),
      .rsp_scan_number   (rsp_scan_number)
   );

endmodule
